[rtl/core/first_fit_block_allocator_defines.svh]
// Assertion macros used by the checker of the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FFBA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[rtl/core/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

	localparam int POOL_BYTES  = 4096;
	localparam int MAX_REGIONS = 32;

	localparam int OFF_W    = 12;
	localparam int LEN_W    = 13;
	localparam int END_W    = LEN_W + 1;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = $clog2(MAX_REGIONS);
	localparam int CNT_W    = $clog2(MAX_REGIONS + 1);

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;
	localparam int S_PAD_W   = S_TDATA_W - LEN_W - OFF_W;
	localparam int M_PAD_W   = M_TDATA_W - STATUS_W - OFF_W;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_NOSPACE,
		ST_BOUNDS,
		ST_FULL
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [OFF_W-1:0] start;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic proc;
		logic fin;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic early;
		logic rd_done;
		logic proc_done;
	} dp_stat_t;

endpackage

[rtl/core/ffba_ctrl.sv]
// Request sequencer of the first-fit block allocator.
module ffba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  ffba_pkg::dp_stat_t   stat,
	output ffba_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		WALK,
		FIN,
		DONE
	} state_t;

	state_t state_q;
	logic   rv_q;
	logic   m_tvalid_q;

	always_comb begin
		cmd.load     = (state_q == IDLE) && s_tvalid;
		cmd.rd       = (state_q == WALK) && !stat.rd_done;
		cmd.proc     = (state_q == WALK) && rv_q;
		cmd.fin      = (state_q == FIN);
		cmd.out_load = (state_q == DONE) && (!m_tvalid_q || m_tready);
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			rv_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rv_q <= cmd.rd;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					state_q <= stat.early ? FIN : WALK;
				end
				WALK: begin
					if (stat.proc_done && !rv_q) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					state_q <= DONE;
				end
				DONE: begin
					if (cmd.out_load) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/ffba_dp.sv]
// Region table, gap search and result registers of the first-fit block allocator.
module ffba_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffba_pkg::ctrl_cmd_t          cmd,
	input  logic                         in_cmd,
	input  logic [ffba_pkg::LEN_W-1:0]   in_length,
	input  logic [ffba_pkg::OFF_W-1:0]   in_offset,
	output ffba_pkg::dp_stat_t           stat,
	output ffba_pkg::status_t            status,
	output logic [ffba_pkg::OFF_W-1:0]   start_res
);

	ffba_pkg::entry_t mem [ffba_pkg::MAX_REGIONS];

	logic                          op_q;
	logic [ffba_pkg::LEN_W-1:0]    len_q;
	logic [ffba_pkg::OFF_W-1:0]    off_q;
	logic [ffba_pkg::CNT_W-1:0]    cnt_q;
	logic [ffba_pkg::CNT_W-1:0]    rd_idx_q;
	logic [ffba_pkg::CNT_W-1:0]    proc_idx_q;
	logic [ffba_pkg::END_W-1:0]    prev_end_q;
	logic                          found_q;
	ffba_pkg::entry_t              carry_q;
	ffba_pkg::entry_t              rdata_q;
	logic [ffba_pkg::OFF_W-1:0]    ins_start_q;
	ffba_pkg::status_t             res_status_q;
	logic [ffba_pkg::OFF_W-1:0]    res_start_q;
	ffba_pkg::status_t             out_status_q;
	logic [ffba_pkg::OFF_W-1:0]    out_start_q;

	logic                          full;
	logic                          bad_len;
	logic                          bounds;
	logic [ffba_pkg::END_W-1:0]    need_end;
	logic [ffba_pkg::END_W-1:0]    entry_end;
	logic                          fit;
	logic                          match;
	logic                          tail_fit;
	logic [ffba_pkg::CNT_W-1:0]    proc_idx_m1;
	ffba_pkg::entry_t              new_entry;
	logic                          we;
	logic [ffba_pkg::IDX_W-1:0]    waddr;
	ffba_pkg::entry_t              wdata;
	ffba_pkg::status_t             fin_status;
	logic [ffba_pkg::OFF_W-1:0]    fin_start;

	localparam logic [ffba_pkg::END_W-1:0] POOL_END = ffba_pkg::END_W'(ffba_pkg::POOL_BYTES);

	always_comb begin
		full      = (cnt_q == ffba_pkg::CNT_W'(ffba_pkg::MAX_REGIONS));
		bad_len   = (len_q == '0) || ({1'b0, len_q} > POOL_END);
		bounds    = ({2'b00, off_q} + {1'b0, len_q}) > POOL_END;
		need_end  = prev_end_q + {1'b0, len_q};
		entry_end = {2'b00, rdata_q.start} + {1'b0, rdata_q.len};
		fit       = {2'b00, rdata_q.start} >= need_end;
		match     = (rdata_q.start == off_q);
		tail_fit  = (need_end <= POOL_END);
		proc_idx_m1     = proc_idx_q - ffba_pkg::CNT_W'(1);
		new_entry.len   = len_q;
		new_entry.start = prev_end_q[ffba_pkg::OFF_W-1:0];

		stat.early     = (op_q == ffba_pkg::CMD_ALLOC) ? (full || bad_len) : bounds;
		stat.rd_done   = (rd_idx_q == cnt_q);
		stat.proc_done = (proc_idx_q == cnt_q);
	end

	always_comb begin
		fin_status = ffba_pkg::ST_OK;
		fin_start  = '0;
		if (op_q == ffba_pkg::CMD_ALLOC) begin
			if (full) begin
				fin_status = ffba_pkg::ST_FULL;
			end else if (bad_len) begin
				fin_status = ffba_pkg::ST_NOSPACE;
			end else if (found_q) begin
				fin_start = ins_start_q;
			end else if (tail_fit) begin
				fin_start = prev_end_q[ffba_pkg::OFF_W-1:0];
			end else begin
				fin_status = ffba_pkg::ST_NOSPACE;
			end
		end else if (bounds) begin
			fin_status = ffba_pkg::ST_BOUNDS;
		end
	end

	// Insertion ripples the displaced entries one place up; removal moves them one place down.
	always_comb begin
		we    = 1'b0;
		waddr = proc_idx_q[ffba_pkg::IDX_W-1:0];
		wdata = carry_q;
		if (cmd.proc) begin
			if (op_q == ffba_pkg::CMD_ALLOC) begin
				if (found_q) begin
					we = 1'b1;
				end else if (fit) begin
					we    = 1'b1;
					wdata = new_entry;
				end
			end else if (found_q) begin
				we    = 1'b1;
				waddr = proc_idx_m1[ffba_pkg::IDX_W-1:0];
				wdata = rdata_q;
			end
		end else if (cmd.fin && (op_q == ffba_pkg::CMD_ALLOC) && (fin_status == ffba_pkg::ST_OK)) begin
			we    = 1'b1;
			waddr = cnt_q[ffba_pkg::IDX_W-1:0];
			wdata = found_q ? carry_q : new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_idx_q[ffba_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			proc_idx_q <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q   <= '0;
				proc_idx_q <= '0;
				found_q    <= 1'b0;
			end
			if (cmd.rd) begin
				rd_idx_q <= rd_idx_q + ffba_pkg::CNT_W'(1);
			end
			if (cmd.proc) begin
				proc_idx_q <= proc_idx_q + ffba_pkg::CNT_W'(1);
				if (!found_q) begin
					if (op_q == ffba_pkg::CMD_ALLOC) begin
						found_q <= fit;
					end else begin
						found_q <= match;
					end
				end
			end
			if (cmd.fin) begin
				if ((op_q == ffba_pkg::CMD_ALLOC) && (fin_status == ffba_pkg::ST_OK)) begin
					cnt_q <= cnt_q + ffba_pkg::CNT_W'(1);
				end else if ((op_q == ffba_pkg::CMD_FREE) && !bounds && found_q) begin
					cnt_q <= cnt_q - ffba_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_cmd;
			len_q      <= in_length;
			off_q      <= in_offset;
			prev_end_q <= '0;
		end
		if (cmd.proc && (op_q == ffba_pkg::CMD_ALLOC)) begin
			if (found_q) begin
				carry_q <= rdata_q;
			end else if (fit) begin
				carry_q     <= rdata_q;
				ins_start_q <= prev_end_q[ffba_pkg::OFF_W-1:0];
			end else begin
				prev_end_q <= entry_end;
			end
		end
		if (cmd.fin) begin
			res_status_q <= fin_status;
			res_start_q  <= fin_start;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
		end
	end

	assign status    = out_status_q;
	assign start_res = out_start_q;

endmodule

[rtl/core/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator.
// A request (allocate or free) is taken only while the block is idle and runs to its end
// before the next is taken. Allocate places the block at the lowest offset that fits in a
// pool of 4096 bytes and answers with that offset; free removes the region that starts at
// the given offset. A request walks the region table, one entry a cycle through its single
// registered read port, over the n regions held (at most 32); an allocate refused because
// the table is full or the length is out of range, and a free out of bounds, skip the walk.
// A result waits in the output register until it is taken, and the next request may be
// accepted meanwhile.
module first_fit_block_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Bits from the lowest up: length [12:0], offset [24:13], zero padding [31:25].
	input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
	// Bit 0: cmd (0 allocate, 1 free).
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Bits from the lowest up: status [1:0], start_res [13:2], zero padding [15:14].
	output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata
);

	ffba_pkg::ctrl_cmd_t          cmd;
	ffba_pkg::dp_stat_t           stat;
	ffba_pkg::status_t            status;
	logic [ffba_pkg::OFF_W-1:0]   start_res;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_cmd    (s_tuser),
		.in_length (s_tdata[ffba_pkg::LEN_W-1:0]),
		.in_offset (s_tdata[ffba_pkg::LEN_W+ffba_pkg::OFF_W-1:ffba_pkg::LEN_W]),
		.stat      (stat),
		.status    (status),
		.start_res (start_res)
	);

	assign m_tdata = {{ffba_pkg::M_PAD_W{1'b0}}, start_res, status};

endmodule

[rtl/core/ffba_checker.sv]
// Port-level assertions of the first-fit block allocator and their binding.
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata
);

	`FFBA_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "Result changed or vanished while stalled.")
	`FFBA_ASSERT(a_start_zero, clk, arst_n, m_tvalid && (m_tdata[1:0] != ffba_pkg::ST_OK) |-> (m_tdata[13:2] == '0), "Offset is not zero on a refused request.")
	`FFBA_ASSERT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "A second request was accepted straight after the first.")
	`FFBA_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !m_tvalid, "Result valid during reset.")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
